@@ rtl/core/mcdf_pkg.sv @@
`timescale 1ns / 1ps
package mcdf_pkg;

  localparam int LANES          = 4;
  localparam int DATA_W         = 16;
  localparam int IDX_W          = 2;
  localparam int CNT_W          = 3;
  localparam int TYPE_W         = 2;
  localparam int ALPHA_W        = 17;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 17;
  localparam int MAX_CHANNELS_DEF   = 4;
  localparam int COEF_FRAC_BITS_DEF = 12;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd58982;
  localparam logic [CNT_W-1:0]   COUNT_RESET = 3'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECOUPLE_TYPE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LP_WEIGHT     = 2'd2;

  localparam logic [1:0] MODE_WR_FF  = 2'd0;
  localparam logic [1:0] MODE_WR_FB  = 2'd1;
  localparam logic [1:0] MODE_SAMPLE = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [TYPE_W-1:0] TYPE_FF = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_FB = 2'd1;

  typedef struct packed {
    logic                          wr_ff;
    logic                          wr_fb;
    logic                          sample;
    logic                          clr;
    logic [IDX_W-1:0]              row;
    logic [IDX_W-1:0]              col;
    logic [DATA_W-1:0]             coef;
    logic [LANES-1:0][DATA_W-1:0]  ref_v;
    logic [LANES-1:0][DATA_W-1:0]  fb_v;
  } item_t;

endpackage

@@ rtl/core/mcdf_front.sv @@
`timescale 1ns / 1ps
module mcdf_front #(
  parameter int MAX_CHANNELS = mcdf_pkg::MAX_CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_mode,
  input  logic [1:0]            in_coef_row,
  input  logic [1:0]            in_coef_col,
  input  logic signed [15:0]    in_coef_value,
  input  logic [3:0][15:0]      in_ref,
  input  logic [3:0][15:0]      in_fb,
  output logic                  item_valid,
  input  logic                  item_ready,
  output mcdf_pkg::item_t       item
);
  import mcdf_pkg::*;

  item_t      q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  item_t      cls;
  logic       push, pop, in_range;

  assign in_range = (32'(in_coef_row) < MAX_CHANNELS) && (32'(in_coef_col) < MAX_CHANNELS);

  always_comb begin
    cls        = '0;
    cls.wr_ff  = (in_mode == MODE_WR_FF) && in_range;
    cls.wr_fb  = (in_mode == MODE_WR_FB) && in_range;
    cls.sample = (in_mode == MODE_SAMPLE);
    cls.clr    = (in_mode == MODE_CLEAR);
    cls.row    = in_coef_row;
    cls.col    = in_coef_col;
    cls.coef   = in_coef_value;
    cls.ref_v  = in_ref;
    cls.fb_v   = in_fb;
  end

  assign in_ready   = (cnt_r != 2'd2);
  assign item_valid = (cnt_r != 2'd0);
  assign item       = q_r[rp_r];
  assign push       = in_valid && in_ready;
  assign pop        = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ rtl/core/mcdf_back.sv @@
`timescale 1ns / 1ps
module mcdf_back #(
  parameter int MAX_CHANNELS   = mcdf_pkg::MAX_CHANNELS_DEF,
  parameter int COEF_FRAC_BITS = mcdf_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  mcdf_pkg::item_t               item,
  input  logic [mcdf_pkg::CNT_W-1:0]    channel_count,
  input  logic [mcdf_pkg::TYPE_W-1:0]   decouple_type,
  input  logic [mcdf_pkg::ALPHA_W-1:0]  lp_weight,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_channel,
  output logic signed [15:0]            out_output_value,
  output logic                          out_last
);
  import mcdf_pkg::*;

  localparam int DEPTH = MAX_CHANNELS * MAX_CHANNELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int HI    = (MAX_CHANNELS < LANES) ? MAX_CHANNELS : LANES;
  localparam int SW    = 36;
  localparam int NW    = SW + 1;
  localparam int ACW   = 60;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_F1    = 3'd3;
  localparam logic [2:0] S_F2    = 3'd4;
  localparam logic [2:0] S_F3    = 3'd5;

  logic [DATA_W-1:0] ff_mem [DEPTH];
  logic [DATA_W-1:0] fb_mem [DEPTH];
  logic [DEPTH-1:0]  ff_vld_r, fb_vld_r;
  logic signed [DATA_W-1:0] filt_r [LANES];

  logic [2:0]        st_r;
  logic [IDX_W-1:0]  i_r, j_r;
  logic [LANES-1:0][DATA_W-1:0] ref_r, fbv_r;
  logic [CNT_W-1:0]  n_r;
  logic [ALPHA_W-1:0] a_r, w_r;
  logic              use_ff_r, use_fb_r;

  logic [DATA_W-1:0] ff_q_r, fb_q_r;
  logic              v1_r, d1_r, v2_r;
  logic [IDX_W-1:0]  jt1_r;
  logic signed [31:0] p_ff_r, p_fb_r;
  logic signed [SW-1:0] sum_r;

  logic signed [33:0] prod_a_r;
  logic [34:0]        prod_lo_r;
  logic signed [18:0] ns_hi_r;
  logic signed [36:0] prod_hi_r;

  logic [AW-1:0]      wa, ra;
  logic [CNT_W-1:0]   n_c;
  logic [ALPHA_W-1:0] a_c;
  logic signed [NW-1:0] ns;
  logic signed [ACW-1:0] acc;
  logic signed [ACW-1:0] y_full;
  logic signed [DATA_W-1:0] y;
  logic               out_free, issue, is_last_j, is_last_i;

  assign wa = AW'(32'(item.row) * MAX_CHANNELS + 32'(item.col));
  assign ra = AW'(32'(i_r) * MAX_CHANNELS + 32'(j_r));

  always_comb begin
    n_c = channel_count;
    if (32'(n_c) > HI) n_c = CNT_W'(HI);
    if (n_c < 3'd2) n_c = 3'd2;
    a_c = (lp_weight > ALPHA_ONE) ? ALPHA_ONE : lp_weight;
  end

  assign item_ready = (st_r == S_IDLE);
  assign issue      = (st_r == S_ISSUE);
  assign is_last_j  = ({1'b0, j_r} == n_r - 3'd1);
  assign is_last_i  = ({1'b0, i_r} == n_r - 3'd1);
  assign out_free   = !out_valid || out_ready;
  assign ns         = -NW'(sum_r);

  always_comb begin
    acc = (ACW'(prod_a_r) <<< COEF_FRAC_BITS) + (ACW'(prod_hi_r) <<< 18)
        + ACW'(signed'({1'b0, prod_lo_r})) + (ACW'(1) <<< (15 + COEF_FRAC_BITS));
    y_full = acc >>> (16 + COEF_FRAC_BITS);
    if (y_full > ACW'(32767)) y = 16'sh7fff;
    else if (y_full < -ACW'(32768)) y = -16'sh8000;
    else y = DATA_W'(y_full);
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready && item.wr_ff) ff_mem[wa] <= item.coef;
    if (item_valid && item_ready && item.wr_fb) fb_mem[wa] <= item.coef;
    ff_q_r <= ff_vld_r[ra] ? ff_mem[ra] : '0;
    fb_q_r <= fb_vld_r[ra] ? fb_mem[ra] : '0;
  end

  always_ff @(posedge clk) begin
    jt1_r  <= j_r;
    d1_r   <= (i_r == j_r);
    p_ff_r <= (use_ff_r && !d1_r)
              ? $signed(ff_q_r) * $signed(ref_r[jt1_r]) : 32'sd0;
    p_fb_r <= (use_fb_r && !d1_r)
              ? $signed(fb_q_r) * $signed(fbv_r[jt1_r]) : 32'sd0;
    if (st_r == S_F1) begin
      prod_a_r  <= $signed({1'b0, a_r}) * filt_r[i_r];
      prod_lo_r <= w_r * ns[17:0];
      ns_hi_r   <= ns[NW-1:18];
    end
    if (st_r == S_F2) prod_hi_r <= ns_hi_r * $signed({1'b0, w_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      ff_vld_r  <= '0;
      fb_vld_r  <= '0;
      for (int k = 0; k < LANES; k++) filt_r[k] <= '0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      out_valid <= 1'b0;
      i_r       <= '0;
      j_r       <= '0;
      sum_r     <= '0;
      n_r       <= COUNT_RESET;
      a_r       <= ALPHA_RESET;
      w_r       <= '0;
      use_ff_r  <= 1'b0;
      use_fb_r  <= 1'b0;
      ref_r     <= '0;
      fbv_r     <= '0;
      out_channel      <= '0;
      out_output_value <= '0;
      out_last         <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      if (v2_r) sum_r <= sum_r + SW'(p_ff_r) + SW'(p_fb_r);
      if (out_valid && out_ready && st_r != S_F3) out_valid <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (item_valid) begin
            if (item.wr_ff) ff_vld_r[wa] <= 1'b1;
            if (item.wr_fb) fb_vld_r[wa] <= 1'b1;
            if (item.clr) for (int k = 0; k < LANES; k++) filt_r[k] <= '0;
            if (item.sample) begin
              ref_r    <= item.ref_v;
              fbv_r    <= item.fb_v;
              n_r      <= n_c;
              a_r      <= a_c;
              w_r      <= ALPHA_ONE - a_c;
              use_ff_r <= (decouple_type != TYPE_FB);
              use_fb_r <= (decouple_type != TYPE_FF);
              i_r      <= '0;
              j_r      <= '0;
              sum_r    <= '0;
              st_r     <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          if (is_last_j) st_r <= S_DRAIN;
          else j_r <= j_r + 2'd1;
        end
        S_DRAIN: begin
          if (!v1_r && !v2_r) st_r <= S_F1;
        end
        S_F1: st_r <= S_F2;
        S_F2: st_r <= S_F3;
        S_F3: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            out_channel      <= i_r;
            out_output_value <= y;
            out_last         <= is_last_i;
            filt_r[i_r]      <= y;
            if (is_last_i) st_r <= S_IDLE;
            else begin
              i_r   <= i_r + 2'd1;
              j_r   <= '0;
              sum_r <= '0;
              st_r  <= S_ISSUE;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/multichannel_decoupling_filter.sv @@
`timescale 1ns / 1ps
// Coefficient writes and clears are registered as the item leaves the queue.
// A sample item runs its n active channels (2 to 4) in turn: per channel one
// coefficient read per cycle, a drain of the products and 3 filter steps.
// Throughput: one item at a time in the back end; a 2-entry queue takes items ahead.
// Reset: synchronous active low; feedforward and feedback matrices and
// filter state read zero, registers return to count 2, feedforward mode, alpha 0.9.
module multichannel_decoupling_filter #(
  parameter int MAX_CHANNELS   = mcdf_pkg::MAX_CHANNELS_DEF,
  parameter int COEF_FRAC_BITS = mcdf_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mcdf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mcdf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_mode,
  input  logic [1:0]                        in_coef_row,
  input  logic [1:0]                        in_coef_col,
  input  logic signed [15:0]                in_coef_value,
  input  logic signed [15:0]                in_ref_ch0,
  input  logic signed [15:0]                in_ref_ch1,
  input  logic signed [15:0]                in_ref_ch2,
  input  logic signed [15:0]                in_ref_ch3,
  input  logic signed [15:0]                in_fb_ch0,
  input  logic signed [15:0]                in_fb_ch1,
  input  logic signed [15:0]                in_fb_ch2,
  input  logic signed [15:0]                in_fb_ch3,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_channel,
  output logic signed [15:0]                out_output_value,
  output logic                              out_last
);
  import mcdf_pkg::*;

  logic [CNT_W-1:0]   channel_count_r;
  logic [TYPE_W-1:0]  decouple_type_r;
  logic [ALPHA_W-1:0] lp_weight_r;
  logic               item_valid, item_ready;
  item_t              item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_count_r <= COUNT_RESET;
      decouple_type_r <= TYPE_FF;
      lp_weight_r     <= ALPHA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHANNEL_COUNT: channel_count_r <= cfg_wdata[CNT_W-1:0];
        CFG_DECOUPLE_TYPE: decouple_type_r <= cfg_wdata[TYPE_W-1:0];
        CFG_LP_WEIGHT:     lp_weight_r     <= cfg_wdata[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  mcdf_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_coef_row   (in_coef_row),
    .in_coef_col   (in_coef_col),
    .in_coef_value (in_coef_value),
    .in_ref        ({in_ref_ch3, in_ref_ch2, in_ref_ch1, in_ref_ch0}),
    .in_fb         ({in_fb_ch3, in_fb_ch2, in_fb_ch1, in_fb_ch0}),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item)
  );

  mcdf_back #(
    .MAX_CHANNELS   (MAX_CHANNELS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item_valid),
    .item_ready       (item_ready),
    .item             (item),
    .channel_count    (channel_count_r),
    .decouple_type    (decouple_type_r),
    .lp_weight        (lp_weight_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_channel      (out_channel),
    .out_output_value (out_output_value),
    .out_last         (out_last)
  );

  a_last_not_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_channel != 2'd0)
    else $error("last flag on channel zero");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_channel)
      && $stable(out_output_value) && $stable(out_last))
    else $error("result changed while stalled");

  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("queue not empty after reset");

endmodule
